[src/vertex_component_to_float_assert.svh]
`ifndef VERTEX_COMPONENT_TO_FLOAT_ASSERT_SVH
`define VERTEX_COMPONENT_TO_FLOAT_ASSERT_SVH
// assertion on the same edge, disabled in reset
`define VCTF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// assertion on the next edge, disabled in reset
`define VCTF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[src/vctf_pkg.sv]
package vctf_pkg;
	localparam logic [2:0] KIND_I8  = 3'd0;
	localparam logic [2:0] KIND_U8  = 3'd1;
	localparam logic [2:0] KIND_I16 = 3'd2;
	localparam logic [2:0] KIND_U16 = 3'd3;
	localparam logic [2:0] KIND_U32 = 3'd4;
	localparam logic [2:0] KIND_F32 = 3'd5;

	localparam logic [1:0] REG_KIND = 2'd0;
	localparam logic [1:0] REG_NORM = 2'd1;

	// biased exponents of the top significand bit
	localparam logic [7:0] EXP_INT  = 8'd158;
	localparam logic [7:0] EXP_ONE  = 8'd127;
	localparam logic [7:0] EXP_FRAC = 8'd126;

	typedef struct packed {
		logic [63:0] w;
		logic [7:0]  exp;
		logic        sign;
		logic        sticky;
		logic        zero;
		logic        pass;
		logic [31:0] pbits;
		logic [31:0] uval;
		logic        uok;
	} vctf_stage_t;
endpackage

[src/vctf_decode.sv]
module vctf_decode (
	input  logic                 clk,
	input  logic                 en,
	input  logic [31:0]          raw_bits,
	input  logic [2:0]           kind,
	input  logic                 norm,
	output vctf_pkg::vctf_stage_t st_s1
);
	import vctf_pkg::*;

	logic        sgn;
	logic [15:0] mag;
	logic [31:0] mag32;
	logic [15:0] div;
	logic        narrow;
	logic [63:0] p7, p8, p15, p16, pat;
	vctf_stage_t nx;

	// sign and magnitude of the component
	always_comb begin
		sgn = 1'b0;
		mag = 16'd0;
		mag32 = raw_bits;
		div = 16'd1;
		narrow = 1'b1;
		case (kind)
			KIND_I8: begin
				sgn = raw_bits[7];
				mag = {8'd0, sgn ? (~raw_bits[7:0] + 8'd1) : raw_bits[7:0]};
				div = 16'd127;
			end
			KIND_U8: begin
				mag = {8'd0, raw_bits[7:0]};
				div = 16'd255;
			end
			KIND_I16: begin
				sgn = raw_bits[15];
				mag = sgn ? (~raw_bits[15:0] + 16'd1) : raw_bits[15:0];
				div = 16'd32767;
			end
			KIND_U16: begin
				mag = raw_bits[15:0];
				div = 16'd65535;
			end
			default: begin
				narrow = 1'b0;
			end
		endcase
		if (narrow)
			mag32 = {16'd0, mag};
	end

	// m / (2^b - 1) is the b-bit pattern of m repeated without end
	always_comb begin
		for (int i = 0; i < 64; i++) begin
			p7[63-i]  = mag[6 - (i % 7)];
			p8[63-i]  = mag[7 - (i % 8)];
			p15[63-i] = mag[14 - (i % 15)];
			p16[63-i] = mag[15 - (i % 16)];
		end
		case (kind)
			KIND_I8:  pat = p7;
			KIND_U8:  pat = p8;
			KIND_I16: pat = p15;
			default:  pat = p16;
		endcase
	end

	// significand word and exponent for the normaliser
	always_comb begin
		nx.sign = sgn;
		nx.pass = (kind == KIND_F32);
		nx.pbits = raw_bits;
		nx.zero = (mag32 == 32'd0);
		nx.w = {mag32, 32'd0};
		nx.exp = EXP_INT;
		nx.sticky = 1'b0;
		if (norm && narrow && (mag != 16'd0)) begin
			if (mag >= div) begin
				nx.w = {1'b1, 63'd0};
				nx.exp = EXP_ONE;
			end else begin
				nx.w = pat;
				nx.exp = EXP_FRAC;
				nx.sticky = 1'b1;
			end
		end
		nx.uok = 1'b1;
		case (kind)
			KIND_U8:  nx.uval = {24'd0, raw_bits[7:0]};
			KIND_U16: nx.uval = {16'd0, raw_bits[15:0]};
			KIND_U32: nx.uval = raw_bits;
			default: begin
				nx.uval = 32'd0;
				nx.uok = 1'b0;
			end
		endcase
	end

	// stage one register
	always_ff @(posedge clk) begin
		if (en)
			st_s1 <= nx;
	end
endmodule

[src/vctf_norm.sv]
module vctf_norm (
	input  logic                 clk,
	input  logic                 en2,
	input  logic                 en3,
	input  vctf_pkg::vctf_stage_t st_s1,
	output vctf_pkg::vctf_stage_t st_s3
);
	import vctf_pkg::*;

	vctf_stage_t a, b, st_s2;

	// coarse leading-zero shift by 32, 16 and 8
	always_comb begin
		a = st_s1;
		if (a.w[63:32] == 32'd0) begin
			a.w = {a.w[31:0], 32'd0};
			a.exp = a.exp - 8'd32;
		end
		if (a.w[63:48] == 16'd0) begin
			a.w = {a.w[47:0], 16'd0};
			a.exp = a.exp - 8'd16;
		end
		if (a.w[63:56] == 8'd0) begin
			a.w = {a.w[55:0], 8'd0};
			a.exp = a.exp - 8'd8;
		end
	end

	always_ff @(posedge clk) begin
		if (en2)
			st_s2 <= a;
	end

	// fine shift by 4, 2 and 1
	always_comb begin
		b = st_s2;
		if (b.w[63:60] == 4'd0) begin
			b.w = {b.w[59:0], 4'd0};
			b.exp = b.exp - 8'd4;
		end
		if (b.w[63:62] == 2'd0) begin
			b.w = {b.w[61:0], 2'd0};
			b.exp = b.exp - 8'd2;
		end
		if (!b.w[63]) begin
			b.w = {b.w[62:0], 1'b0};
			b.exp = b.exp - 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3)
			st_s3 <= b;
	end
endmodule

[src/vctf_round.sv]
module vctf_round (
	input  logic                 clk,
	input  logic                 en,
	input  vctf_pkg::vctf_stage_t st_s3,
	output logic [31:0]          float_bits,
	output logic [31:0]          unsigned_value,
	output logic                 unsigned_ok
);
	import vctf_pkg::*;

	logic        guard, stk, inc;
	logic [24:0] sum;
	logic [7:0]  e;
	logic [22:0] frac;
	logic [31:0] fb;

	// round to nearest even and pack
	always_comb begin
		guard = st_s3.w[39];
		stk = (|st_s3.w[38:0]) | st_s3.sticky;
		inc = guard & (stk | st_s3.w[40]);
		sum = {1'b0, st_s3.w[63:40]} + {24'd0, inc};
		e = st_s3.exp;
		frac = sum[22:0];
		if (sum[24]) begin
			e = st_s3.exp + 8'd1;
			frac = 23'd0;
		end
		if (st_s3.pass)
			fb = st_s3.pbits;
		else if (st_s3.zero)
			fb = 32'd0;
		else
			fb = {st_s3.sign, e, frac};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			float_bits <= fb;
			unsigned_value <= st_s3.uval;
			unsigned_ok <= st_s3.uok;
		end
	end
endmodule

[src/vertex_component_to_float.sv]
// channel   | handshake            | payload
// request   | in_valid, in_ready   | raw_bits
// result    | out_valid, out_ready | float_bits, unsigned_value, unsigned_ok
// config    | cfg_we               | cfg_index, cfg_data
//
// four register stages: decode, coarse shift, fine shift, round into the output register
// one request per cycle while in_ready is high; out_valid rises after v_s1, v_s2, v_s3
// in_ready drops only when every stage holds a request and out_ready is low
// arst_n clears the stage valid bits and sets kind u8, normalisation off
module vertex_component_to_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] raw_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] float_bits,
	output logic [31:0] unsigned_value,
	output logic        unsigned_ok
);
	import vctf_pkg::*;

	logic [2:0]  kind_q;
	logic        norm_q;
	logic        v_s1, v_s2, v_s3;
	logic        en1, en2, en3, en4;
	vctf_stage_t st_s1, st_s3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_U8;
			norm_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KIND)
				kind_q <= cfg_data;
			else if (cfg_index == REG_NORM)
				norm_q <= cfg_data[0];
		end
	end

	// stage advance, a stage moves when empty or its successor moves
	assign en4 = !out_valid | out_ready;
	assign en3 = !v_s3 | en4;
	assign en2 = !v_s2 | en3;
	assign en1 = !v_s1 | en2;
	assign in_ready = en1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) out_valid <= v_s3;
		end
	end

	vctf_decode u_dec (
		.clk(clk), .en(en1), .raw_bits(raw_bits), .kind(kind_q), .norm(norm_q),
		.st_s1(st_s1)
	);

	vctf_norm u_norm (
		.clk(clk), .en2(en2), .en3(en3), .st_s1(st_s1), .st_s3(st_s3)
	);

	vctf_round u_rnd (
		.clk(clk), .en(en4), .st_s3(st_s3), .float_bits(float_bits),
		.unsigned_value(unsigned_value), .unsigned_ok(unsigned_ok)
	);
endmodule

[src/vctf_checker.sv]
`include "vertex_component_to_float_assert.svh"
module vctf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] float_bits,
	input logic [31:0] unsigned_value,
	input logic        unsigned_ok
);
	// a stalled result stays
	`VCTF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(float_bits))
	// signed and float kinds give a zero unsigned result
	`VCTF_ASSERT_NOW(a_uzero, out_valid && !unsigned_ok, unsigned_value == 32'd0)
	// unsigned kinds never give a negative float
	`VCTF_ASSERT_NOW(a_upos, out_valid && unsigned_ok, !float_bits[31])
	// a free output side never blocks requests
	`VCTF_ASSERT_NOW(a_ready, out_ready, in_ready)
endmodule

bind vertex_component_to_float vctf_checker u_chk (.*);

[tb/tb_vertex_component_to_float.sv]
`timescale 1ns / 1ps

module tb_vertex_component_to_float;
	import vctf_pkg::*;

	typedef struct {
		logic [31:0] fbits;
		logic [31:0] uval;
		logic        uok;
	} conversion_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [2:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] raw_bits;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] float_bits;
	logic [31:0] unsigned_value;
	logic        unsigned_ok;

	vertex_component_to_float dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .raw_bits(raw_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.float_bits(float_bits), .unsigned_value(unsigned_value),
		.unsigned_ok(unsigned_ok)
	);

	// shadow of the block's registers
	logic [2:0]  cur_kind;
	logic        cur_norm;

	logic [31:0] raw_pending[$];
	conversion_t conversions_due[$];
	int          mismatches;
	bit          quiet;
	bit          took;
	int          send_gap;
	int          recv_gap;
	int          hold_cycles;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// double to single, round to nearest even; no overflow or subnormal reachable
	function automatic logic [31:0] to_single(real r);
		logic [63:0] d;
		logic [31:0] s;
		logic [10:0] e;
		d = $realtobits(r);
		e = d[62:52];
		if (e == 11'd0) begin
			return {d[63], 31'd0};
		end
		s = {d[63], 8'(e - 11'd1023 + 11'd127), d[51:29]};
		if (d[28] && ((|d[27:0]) || d[29]))
			s[30:0] = s[30:0] + 31'd1;
		return s;
	endfunction

	// expected conversion of one component
	function automatic conversion_t convert_component(logic [2:0] kind, logic norm,
			logic [31:0] raw);
		conversion_t c;
		real v;
		real div;
		c.uval = 32'd0;
		c.uok  = 1'b0;
		div    = 1.0;
		case (kind)
			KIND_I8:  begin v = real'(int'($signed(raw[7:0])));   div = 127.0;   end
			KIND_U8:  begin v = real'(raw[7:0]);                   div = 255.0;   end
			KIND_I16: begin v = real'(int'($signed(raw[15:0])));  div = 32767.0; end
			KIND_U16: begin v = real'(raw[15:0]);                  div = 65535.0; end
			default:  v = real'(raw);
		endcase
		if (kind == KIND_F32) begin
			c.fbits = raw;
		end else if (norm) begin
			v = v / div;
			c.fbits = (v < -1.0) ? 32'hBF80_0000 : to_single(v);
		end else begin
			c.fbits = to_single(v);
		end
		if (kind == KIND_U8) begin
			c.uval = {24'd0, raw[7:0]};
			c.uok  = 1'b1;
		end else if (kind == KIND_U16) begin
			c.uval = {16'd0, raw[15:0]};
			c.uok  = 1'b1;
		end else if (kind == KIND_U32) begin
			c.uval = raw;
			c.uok  = 1'b1;
		end
		return c;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h (kind %0d norm %0d)", what, got, want,
			cur_kind, cur_norm);
		mismatches++;
	endtask

	// biased towards sign and range boundaries
	function automatic logic [31:0] pick_raw();
		logic [31:0] edges[10] = '{32'h0, 32'h7F, 32'h80, 32'hFF, 32'h7FFF, 32'h8000,
			32'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FC0_0001};
		case ($urandom_range(0, 3))
			0: return edges[$urandom_range(0, 9)];
			1: return 32'({$urandom(), 8'h0}) | 32'($urandom_range(0, 255));
			default: return $urandom();
		endcase
	endfunction

	// sender: acceptance at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			conversions_due.insert(conversions_due.size(),
				convert_component(cur_kind, cur_norm, raw_bits));
			took = 1'b1;
		end
	end

	// sender: next request at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took)) begin
			took = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (raw_pending.size() > 0) begin
				raw_bits <= raw_pending.pop_front();
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 15) == 0)
					send_gap = $urandom_range(1, 19);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stalls and the long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 15) == 0)
					recv_gap = $urandom_range(1, 19);
			end
		end
	end

	// checker
	always @(posedge clk) begin
		conversion_t w;
		if (arst_n && out_valid && out_ready) begin
			if (conversions_due.size() == 0) begin
				report_mismatch("result with nothing outstanding", float_bits, 32'd0);
			end else begin
				w = conversions_due.pop_front();
				if (float_bits !== w.fbits)
					report_mismatch("float_bits", float_bits, w.fbits);
				if (unsigned_value !== w.uval)
					report_mismatch("unsigned_value", unsigned_value, w.uval);
				if (unsigned_ok !== w.uok)
					report_mismatch("unsigned_ok", {31'd0, unsigned_ok}, {31'd0, w.uok});
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [2:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KIND)
			cur_kind = val;
		else
			cur_norm = val[0];
	endtask

	task automatic drain();
		while (raw_pending.size() > 0 || in_valid || conversions_due.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [31:0] directed[$] = '{32'h0, 32'h1, 32'h7F, 32'h80, 32'h81, 32'hFF,
			32'h7FFF, 32'h8000, 32'hFFFF, 32'h1_0000, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'h00FF_FFFF, 32'h0100_0001,
			32'hFFFF_FF01, 32'h1234_5678, 32'hDEAD_BEEF};
		logic [3:0] setting;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		raw_bits    = '0;
		out_ready   = 1'b0;
		mismatches  = 0;
		quiet       = 1'b0;
		took        = 1'b0;
		send_gap    = 0;
		recv_gap    = 0;
		hold_cycles = 0;
		cur_kind    = KIND_U8;
		cur_norm    = 1'b0;
		arst_n      = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings
		foreach (directed[i])
			raw_pending.insert(raw_pending.size(), directed[i]);
		drain();

		// random, every kind with and without normalisation
		for (int pass = 0; pass < 2; pass++) begin
			for (int k = 0; k < 16; k++) begin
				setting = 4'(k);
				write_reg(REG_KIND, setting[3:1]);
				write_reg(REG_NORM, {2'd0, setting[0]});
				if (pass == 1 && k >= 12)
					quiet = 1'b1;
				for (int n = 0; n < 50; n++)
					raw_pending.insert(raw_pending.size(), pick_raw());
				// long receiver hold-off while requests keep coming
				if (pass == 0 && k == 3)
					hold_cycles = 80;
				drain();
			end
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// timeout
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

[files.f]
+incdir+src
src/vctf_pkg.sv
src/vctf_decode.sv
src/vctf_norm.sv
src/vctf_round.sv
src/vertex_component_to_float.sv
src/vctf_checker.sv
tb/tb_vertex_component_to_float.sv
